// ----- hdl/tpg_pkg.sv -----
// Shared types, constants and pattern tables of the test pattern generator.
`default_nettype none

package tpg_pkg;

  localparam int COORD_W = 8;
  localparam int GREY_W  = 8;
  localparam int MODE_W  = 4;
  localparam int D2_W    = 16;
  localparam int IDX_W   = COORD_W + 1;
  localparam int RAD_W   = 18;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int ROM_DEPTH = 511;

  // root unit: nine digit steps spread over three stages
  localparam int SQRT_STAGES = 3;
  localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;

  localparam logic [COORD_W-1:0] CENTER = COORD_W'(128);

  // pattern select codes
  localparam logic [MODE_W-1:0] MODE_RESET        = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_RAMP         = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_PRODUCT      = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_SUM          = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_DIFF         = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_ROOT_PRODUCT = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_RADIAL       = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_RADIAL_WRAP  = MODE_W'(7);
  localparam logic [MODE_W-1:0] MODE_COS          = MODE_W'(8);
  localparam logic [MODE_W-1:0] MODE_SIN          = MODE_W'(9);

  // radial scaling: 65025*d2/32768 and 65025*d2/16129
  localparam int P6_W     = 31;
  localparam int N7_W     = 24;
  localparam int RECIP_W  = 25;
  localparam int Q7_W     = 11;
  localparam int unsigned R6_MUL   = 65025;
  localparam int unsigned R6_SHIFT = 15;
  localparam int unsigned R7_DIV   = 16129;
  localparam int unsigned R7_INT   = R6_MUL / R7_DIV;
  localparam int unsigned R7_FRAC  = R6_MUL - R7_INT * R7_DIV;
  localparam int unsigned R7_RECIP_SHIFT = 38;
  // ceil(2^38/16129): exact quotient for any numerator below 2^24
  localparam longint unsigned R7_RECIP =
    ((64'd1 << R7_RECIP_SHIFT) + 64'(R7_DIV) - 64'd1) / 64'(R7_DIV);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIRECT,
    OP_ROOT_XY,
    OP_ROOT_R6,
    OP_ROOT_R7,
    OP_COS,
    OP_SIN
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [GREY_W-1:0]    val;
    logic [2*COORD_W-1:0] xy;
    logic [D2_W-1:0]      d2;
    logic [IDX_W-1:0]     idx;
  } s1_t;

  typedef struct packed {
    op_t                  op;
    logic [GREY_W-1:0]    val;
    logic [2*COORD_W-1:0] xy;
    logic [D2_W-1:0]      d2;
    logic [P6_W-1:0]      p6;
    logic [N7_W-1:0]      n7;
  } s2_t;

  typedef struct packed {
    logic              written;
    logic              use_root;
    logic [GREY_W-1:0] val;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // ---------------------------------------------------------------------
  // |cos| and |sin| tables, built at elaboration in Q61 fixed point
  // ---------------------------------------------------------------------
  localparam int SERIES_TERMS = 14;
  localparam logic [63:0] HALF_PI_Q59 = 64'h3243F6A8885A308D >> 2;
  localparam logic [63:0] ONE_Q61     = 64'd1 << 61;

  localparam logic [SERIES_TERMS-1:0][9:0] COS_DIV = {
    10'd756, 10'd650, 10'd552, 10'd462, 10'd380, 10'd306, 10'd240,
    10'd182, 10'd132, 10'd90,  10'd56,  10'd30,  10'd12,  10'd2
  };
  localparam logic [SERIES_TERMS-1:0][9:0] SIN_DIV = {
    10'd812, 10'd702, 10'd600, 10'd506, 10'd420, 10'd342, 10'd272,
    10'd210, 10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6
  };

  typedef logic [ROM_DEPTH-1:0][GREY_W-1:0] rom_t;

  function automatic logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[124:61];
  endfunction

  function automatic logic [63:0] clamp_q61(logic [63:0] s);
    if (s[63]) return 64'd0;
    if (s > ONE_Q61) return ONE_Q61;
    return s;
  endfunction

  function automatic logic [63:0] cos_series(logic [63:0] x2);
    logic [63:0] term;
    logic [63:0] sum;
    term = ONE_Q61;
    sum  = ONE_Q61;
    for (int n = 0; n < SERIES_TERMS; n++) begin
      term = mul_q61(term, x2) / 64'(COS_DIV[n]);
      if (!n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return clamp_q61(sum);
  endfunction

  function automatic logic [63:0] sin_series(logic [63:0] x2, logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = x;
    sum  = x;
    for (int n = 0; n < SERIES_TERMS; n++) begin
      term = mul_q61(term, x2) / 64'(SIN_DIV[n]);
      if (!n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return clamp_q61(sum);
  endfunction

  function automatic logic [GREY_W-1:0] scale255(logic [63:0] v);
    logic [71:0] p;
    p = 72'(v) * 72'd255;
    return GREY_W'(p >> 61);
  endfunction

  function automatic logic [GREY_W-1:0] trig_entry(int unsigned k, logic want_sin);
    logic [127:0] theta;
    logic [127:0] quad;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  v;
    logic         use_sin;
    theta   = ((128'(k) * 128'd157) << 59) / 128'd9000;
    quad    = theta / 128'(HALF_PI_Q59);
    x       = 64'((theta - quad * 128'(HALF_PI_Q59)) << 2);
    x2      = mul_q61(x, x);
    use_sin = want_sin ^ quad[0];
    v       = use_sin ? sin_series(x2, x) : cos_series(x2);
    return scale255(v);
  endfunction

  function automatic rom_t build_rom(logic want_sin);
    rom_t r;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      r[IDX_W'(k)] = trig_entry(k, want_sin);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom(1'b0);
  localparam rom_t SIN_ROM = build_rom(1'b1);

endpackage

`default_nettype wire

// ----- hdl/tpg_if.sv -----
// Channel interfaces of the test pattern generator: coordinates, pixels, config.
`default_nettype none

interface tpg_coord_if import tpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface tpg_pixel_if import tpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GREY_W-1:0] grey_value;
  logic              pixel_written;
  modport source (output valid, grey_value, pixel_written, input ready);
  modport sink   (input valid, grey_value, pixel_written, output ready);
endinterface

interface tpg_cfg_if import tpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] pattern_mode;
  modport source (output valid, pattern_mode, input ready);
  modport sink   (input valid, pattern_mode, output ready);
endinterface

`default_nettype wire

// ----- hdl/tpg_front.sv -----
// Front stages: coordinate math, table read, radial scaling, root radicand.
`default_nettype none

module tpg_front import tpg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] mode,
  tpg_coord_if.sink         in_if,
  output logic              dn_valid,
  input  logic              dn_ready,
  output sq_t               dn_data
);

  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  sq_t  s3_r, s3_nxt;

  assign s3_rdy = !s3_v_r || dn_ready;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_if.ready = s1_rdy;
  assign dn_valid = s3_v_r;
  assign dn_data  = s3_r;

  // stage 1: distances, product, sum, pattern decode
  logic [COORD_W-1:0]   x, y, dx, dy, diff;
  logic [COORD_W:0]     sum_xy;
  logic [2*COORD_W-1:0] prod_xy;

  always_comb begin
    x       = in_if.column;
    y       = in_if.row;
    dx      = (x >= CENTER) ? x - CENTER : CENTER - x;
    dy      = (y >= CENTER) ? y - CENTER : CENTER - y;
    diff    = (x > y) ? x - y : y - x;
    sum_xy  = IDX_W'(x) + IDX_W'(y);
    prod_xy = (2*COORD_W)'(x) * (2*COORD_W)'(y);
    s1_nxt.xy  = prod_xy;
    s1_nxt.d2  = D2_W'(dx) * D2_W'(dx) + D2_W'(dy) * D2_W'(dy);
    s1_nxt.idx = sum_xy;
    s1_nxt.val = '0;
    case (mode)
      MODE_RAMP: begin
        s1_nxt.op  = OP_DIRECT;
        s1_nxt.val = x;
      end
      MODE_PRODUCT: begin
        s1_nxt.op  = OP_DIRECT;
        s1_nxt.val = prod_xy[GREY_W-1:0];
      end
      MODE_SUM: begin
        s1_nxt.op  = OP_DIRECT;
        s1_nxt.val = sum_xy[GREY_W-1:0];
      end
      MODE_DIFF: begin
        s1_nxt.op  = OP_DIRECT;
        s1_nxt.val = diff;
      end
      MODE_ROOT_PRODUCT: s1_nxt.op = OP_ROOT_XY;
      MODE_RADIAL:       s1_nxt.op = OP_ROOT_R6;
      MODE_RADIAL_WRAP:  s1_nxt.op = OP_ROOT_R7;
      MODE_COS:          s1_nxt.op = OP_COS;
      MODE_SIN:          s1_nxt.op = OP_SIN;
      default:           s1_nxt.op = OP_NONE;
    endcase
  end

  // stage 2: table read, constant products of d2
  always_comb begin
    s2_nxt.op = s1_r.op;
    s2_nxt.xy = s1_r.xy;
    s2_nxt.d2 = s1_r.d2;
    s2_nxt.p6 = P6_W'(32'(s1_r.d2) * 32'(R6_MUL));
    s2_nxt.n7 = N7_W'(32'(s1_r.d2) * 32'(R7_FRAC));
    case (s1_r.op)
      OP_COS:  s2_nxt.val = COS_ROM[s1_r.idx];
      OP_SIN:  s2_nxt.val = SIN_ROM[s1_r.idx];
      default: s2_nxt.val = s1_r.val;
    endcase
  end

  // stage 3: radicand; d2*65025/16129 = 4*d2 + floor(509*d2/16129)
  logic [N7_W+RECIP_W-1:0] q7_prod;
  logic [Q7_W-1:0]         q7;

  always_comb begin
    q7_prod = (N7_W+RECIP_W)'(s2_r.n7) * (N7_W+RECIP_W)'(R7_RECIP);
    q7      = Q7_W'(q7_prod >> R7_RECIP_SHIFT);
    s3_nxt.written  = (s2_r.op != OP_NONE);
    s3_nxt.use_root = (s2_r.op == OP_ROOT_XY) || (s2_r.op == OP_ROOT_R6) ||
                      (s2_r.op == OP_ROOT_R7);
    s3_nxt.val  = s2_r.val;
    s3_nxt.rem  = '0;
    s3_nxt.root = '0;
    case (s2_r.op)
      OP_ROOT_XY: s3_nxt.rad = RAD_W'(s2_r.xy);
      OP_ROOT_R6: s3_nxt.rad = RAD_W'(s2_r.p6 >> R6_SHIFT);
      OP_ROOT_R7: s3_nxt.rad = RAD_W'(s2_r.d2) * RAD_W'(R7_INT) + RAD_W'(q7);
      default:    s3_nxt.rad = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_if.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_if.valid) s1_r <= s1_nxt;
    if (s2_rdy && s1_v_r) s2_r <= s2_nxt;
    if (s3_rdy && s2_v_r) s3_r <= s3_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/tpg_sqrt_stage.sv -----
// One register stage of the integer square root: SQRT_STEPS restoring digit steps.
`default_nettype none

module tpg_sqrt_stage import tpg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  sq_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output sq_t  dn_data
);

  // bring down the next two radicand bits, try root*4+1
  function automatic sq_t root_step(sq_t s);
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    sq_t              r;
    r     = s;
    acc   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    return r;
  endfunction

  logic v_r;
  sq_t  data_r, data_nxt;
  sq_t  steps [SQRT_STEPS+1];

  always_comb begin
    steps[0] = up_data;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      steps[i+1] = root_step(steps[i]);
    end
    data_nxt = steps[SQRT_STEPS];
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/test_pattern_generator.sv -----
// Top level of the video test pattern generator.
`default_nettype none

// Takes one coordinate word (column, row) per clock and returns one pixel word
// with the grey value of the selected pattern and a written flag. Throughput is
// one word per clock while the output is not stalled. The word passes six
// register stages on the way to the output. The three front stages are:
// coordinate math; table read and constant multiplies; reciprocal divide
// by 16129 to form the radicand. Then come three stages of the nine-step
// square root, three digits each. Every stage has its own valid bit and takes
// a new word whenever it is empty or its successor moves. Under an output
// stall the bubbles close up, and the input is held only once every stage is
// full. pattern_mode resets to 1 and is written through the config channel,
// which is always ready; write it only while no word is in flight. Modes 0 and
// 10..15 return grey 0 with pixel_written low.

module test_pattern_generator import tpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tpg_cfg_if.sink     cfg_if,
  tpg_coord_if.sink   in_if,
  tpg_pixel_if.source out_if
);

  logic [MODE_W-1:0] mode_r;

  // config register, one word per clock
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_if.valid) begin
      mode_r <= cfg_if.pattern_mode;
    end
  end

  // pipeline links: index 0 is the front output, the last feeds the port
  logic [SQRT_STAGES:0] sq_v;
  logic [SQRT_STAGES:0] sq_rdy;
  sq_t                  sq_d [SQRT_STAGES+1];

  tpg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .in_if    (in_if),
    .dn_valid (sq_v[0]),
    .dn_ready (sq_rdy[0]),
    .dn_data  (sq_d[0])
  );

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_root
    tpg_sqrt_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[g]),
      .up_ready (sq_rdy[g]),
      .up_data  (sq_d[g]),
      .dn_valid (sq_v[g+1]),
      .dn_ready (sq_rdy[g+1]),
      .dn_data  (sq_d[g+1])
    );
  end

  // root patterns take the low byte of the root (radial wrap keeps 8 of 9 bits)
  assign sq_rdy[SQRT_STAGES]  = out_if.ready;
  assign out_if.valid         = sq_v[SQRT_STAGES];
  assign out_if.pixel_written = sq_d[SQRT_STAGES].written;
  assign out_if.grey_value    = sq_d[SQRT_STAGES].use_root ?
                                sq_d[SQRT_STAGES].root[GREY_W-1:0] :
                                sq_d[SQRT_STAGES].val;

  // a word that is not written carries grey 0
  a_nowrite_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.pixel_written |-> out_if.grey_value == '0)
    else $error("unwritten pixel word with nonzero grey");

  // finished root: remainder never exceeds twice the root
  a_root_rem : assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[SQRT_STAGES] |->
      sq_d[SQRT_STAGES].rem <= REM_W'({sq_d[SQRT_STAGES].root, 1'b0}))
    else $error("square root remainder out of range");

  // input backs up only behind a held output word
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input stalled while output is free");

  // a held output word is still there next clock
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("output word dropped under stall");

endmodule

`default_nettype wire
